// ===== rtl/osup_pkg.sv =====
// Shared types and constants for the oversampled dual serial channel block.
// No dependencies; used by osup_rx, osup_tx and oversampled_soft_uart_pair.
`timescale 1ns / 1ps

package osup_pkg;

    // Channel count default
    localparam int CHANNELS_DEF = 2;

    // Frame shape
    localparam int DATA_BITS     = 8;
    localparam int TX_LAST_INDEX = 9;

    // Timing register widths and reset values
    localparam int TICK_W               = 8;
    localparam int BIT_IDX_W            = 4;
    localparam logic [7:0] FIRST_SAMPLE_RST = 8'd24;
    localparam logic [7:0] BIT_TICKS_RST    = 8'd16;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_SAMPLE = 1'b0,
        REG_BIT_TICKS    = 1'b1
    } cfg_reg_t;

    // Receiver phases
    typedef enum logic [1:0] {
        RX_IDLE   = 2'd0,
        RX_SAMPLE = 2'd1,
        RX_STOP   = 2'd2,
        RX_HOLD   = 2'd3
    } rx_phase_t;

    // Transmitter phases
    typedef enum logic [1:0] {
        TX_IDLE = 2'd0,
        TX_SEND = 2'd1,
        TX_LAST = 2'd2
    } tx_phase_t;

    // Timing settings handed to every channel
    typedef struct packed {
        logic [TICK_W-1:0] first_sample_ticks;
        logic [TICK_W-1:0] bit_ticks;
    } timing_t;

endpackage

// ===== rtl/osup_rx.sv =====
// Receiver of one serial channel: start detect, timed sampling, byte hold.
// Depends on osup_pkg.
`timescale 1ns / 1ps

module osup_rx (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    tick,
    input  logic                    level,
    input  logic                    ack,
    input  osup_pkg::timing_t       timing,
    output logic                    ready,
    output logic [7:0]              rx_byte
);
    import osup_pkg::*;

    rx_phase_t              phase_reg, phase_next, phase_cur;
    logic [TICK_W-1:0]      cd_reg, cd_next;
    logic [BIT_IDX_W-1:0]   idx_reg, idx_next, idx_inc;
    logic [DATA_BITS-1:0]   shift_reg, shift_next;

    // Hold state until the next tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= RX_IDLE;
            cd_reg    <= '0;
            idx_reg   <= '0;
            shift_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            cd_reg    <= cd_next;
            idx_reg   <= idx_next;
            shift_reg <= shift_next;
        end
    end

    assign idx_inc = idx_reg + 4'd1;

    // Apply the ack first, then advance one tick
    always_comb begin
        phase_cur  = (ack && phase_reg == RX_HOLD) ? RX_IDLE : phase_reg;
        phase_next = phase_reg;
        cd_next    = cd_reg;
        idx_next   = idx_reg;
        shift_next = shift_reg;
        if (tick) begin
            phase_next = phase_cur;
            unique case (phase_cur)
                RX_IDLE: begin
                    if (!level) begin
                        phase_next = RX_SAMPLE;
                        cd_next    = timing.first_sample_ticks;
                        idx_next   = '0;
                        shift_next = '0;
                    end
                end
                RX_SAMPLE: begin
                    if (cd_reg <= 8'd1) begin
                        shift_next = shift_reg | ({7'd0, level} << idx_reg[2:0]);
                        cd_next    = timing.bit_ticks;
                        idx_next   = idx_inc;
                        if (idx_inc >= BIT_IDX_W'(DATA_BITS)) begin
                            phase_next = RX_STOP;
                        end
                    end else begin
                        cd_next = cd_reg - 8'd1;
                    end
                end
                RX_STOP: begin
                    if (level) begin
                        phase_next = RX_HOLD;
                    end
                end
                RX_HOLD: begin
                    phase_next = RX_HOLD;
                end
                default: begin
                    phase_next = RX_IDLE;
                end
            endcase
        end
    end

    assign ready   = (phase_reg == RX_HOLD);
    assign rx_byte = ready ? shift_reg : 8'd0;

endmodule

// ===== rtl/osup_tx.sv =====
// Transmitter of one serial channel: start bit, eight data bits, then the line returns high.
// Depends on osup_pkg.
`timescale 1ns / 1ps

module osup_tx (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    tick,
    input  logic                    start,
    input  logic [7:0]              tx_byte,
    input  osup_pkg::timing_t       timing,
    output logic                    line,
    output logic                    busy
);
    import osup_pkg::*;

    tx_phase_t              phase_reg, phase_next;
    logic [TICK_W-1:0]      cd_reg, cd_next;
    logic [BIT_IDX_W-1:0]   idx_reg, idx_next, idx_inc, idx_m1;
    logic [DATA_BITS-1:0]   data_reg, data_next;
    logic                   line_reg, line_next;

    // Hold state until the next tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= TX_IDLE;
            cd_reg    <= '0;
            idx_reg   <= '0;
            data_reg  <= '0;
            line_reg  <= 1'b1;
        end else begin
            phase_reg <= phase_next;
            cd_reg    <= cd_next;
            idx_reg   <= idx_next;
            data_reg  <= data_next;
            line_reg  <= line_next;
        end
    end

    assign busy    = (phase_reg == TX_SEND) || (phase_reg == TX_LAST);
    assign idx_inc = idx_reg + 4'd1;
    assign idx_m1  = idx_reg - 4'd1;

    // A granted request drives the start bit on the same tick
    always_comb begin
        phase_next = phase_reg;
        cd_next    = cd_reg;
        idx_next   = idx_reg;
        data_next  = data_reg;
        line_next  = line_reg;
        if (tick) begin
            priority if (start && !busy) begin
                data_next  = tx_byte;
                line_next  = 1'b0;
                idx_next   = 4'd1;
                cd_next    = timing.bit_ticks;
                phase_next = TX_SEND;
            end else if (phase_reg == TX_SEND) begin
                if (cd_reg <= 8'd1) begin
                    line_next = (idx_reg == 4'd0) ? 1'b0 : data_reg[idx_m1[2:0]];
                    idx_next  = idx_inc;
                    cd_next   = timing.bit_ticks;
                    if (idx_inc >= BIT_IDX_W'(TX_LAST_INDEX)) begin
                        phase_next = TX_LAST;
                    end
                end else begin
                    cd_next = cd_reg - 8'd1;
                end
            end else if (phase_reg == TX_LAST) begin
                if (cd_reg <= 8'd1) begin
                    line_next  = 1'b1;
                    phase_next = TX_IDLE;
                end else begin
                    cd_next = cd_reg - 8'd1;
                end
            end
        end
    end

    assign line = line_reg;

endmodule

// ===== rtl/oversampled_soft_uart_pair.sv =====
// Top level: timing registers, tick stream handshake and the channel array.
// Depends on osup_pkg, osup_rx and osup_tx.
`timescale 1ns / 1ps

// Usage
// Each request on the s_ channel is one oversampling tick: receive line
// levels, acks and an optional send request. Every request yields exactly one
// result on the m_ channel with the transmit lines, receive status, held
// bytes, transmitter busy flags and the send reject flag after that tick.
// The result is registered and presented the cycle after the request
// is taken. Throughput is one request per cycle; the channel state registers
// double as the result register, and s_tready stays high while the result is
// taken in the same cycle, so only a stalled m_ side blocks new requests.
// When m_tready is low the result holds and s_tready drops until it is taken.
// The cfg_ write channel is always ready; write it only while no result is
// pending. Reset (aresetn low, synchronous) idles all channels, drives the
// transmit lines high and loads 24 and 16 into the timing registers.
module oversampled_soft_uart_pair #(
    parameter int CHANNELS = osup_pkg::CHANNELS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // rx_left, rx_right, send_request, send_byte[7:0], ack_left, ack_right
    input  logic [osup_pkg::S_TDATA_W-1:0]      s_tdata,
    // send_channel
    input  logic                                s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tx_left, tx_right, ready_left, ready_right, byte_left[7:0],
    // byte_right[7:0], busy_left, busy_right, send_rejected
    output logic [osup_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [osup_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [osup_pkg::TICK_W-1:0]         cfg_data
);
    import osup_pkg::*;

    timing_t                timing_reg, timing_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   rejected_reg, rejected_next;
    logic                   tick;

    // Unpacked request fields
    logic                   rx_left, rx_right, send_request, ack_left, ack_right;
    logic [7:0]             send_byte;
    logic                   send_channel;

    logic [CHANNELS-1:0]    start, busy, line, ready;
    logic [7:0]             rx_byte [CHANNELS];

    // Result fields, absent channels read idle
    logic                   tx_r, busy_r, ready_r;
    logic [7:0]             byte_r;

    assign rx_left      = s_tdata[0];
    assign rx_right     = s_tdata[1];
    assign send_request = s_tdata[2];
    assign send_byte    = s_tdata[10:3];
    assign ack_left     = s_tdata[11];
    assign ack_right    = s_tdata[12];
    assign send_channel = s_tuser;

    assign s_tready  = !m_valid_reg || m_tready;
    assign tick      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Timing register writes
    always_comb begin
        timing_next = timing_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_FIRST_SAMPLE: timing_next.first_sample_ticks = cfg_data;
                REG_BIT_TICKS:    timing_next.bit_ticks          = cfg_data;
                default:          timing_next = timing_reg;
            endcase
        end
    end

    // Result valid and reject flag
    always_comb begin
        m_valid_next  = m_valid_reg;
        rejected_next = rejected_reg;
        if (tick) begin
            m_valid_next  = 1'b1;
            rejected_next = send_request && !(|(start & ~busy));
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.first_sample_ticks <= FIRST_SAMPLE_RST;
            timing_reg.bit_ticks          <= BIT_TICKS_RST;
            m_valid_reg                   <= 1'b0;
            rejected_reg                  <= 1'b0;
        end else begin
            timing_reg   <= timing_next;
            m_valid_reg  <= m_valid_next;
            rejected_reg <= rejected_next;
        end
    end

    // Channel array; channels past the two line fields see an idle line
    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
        logic level_g, ack_g;
        if (g == 0) begin : g_left
            assign level_g  = rx_left;
            assign ack_g    = ack_left;
            assign start[g] = send_request && !send_channel;
        end else if (g == 1) begin : g_right
            assign level_g  = rx_right;
            assign ack_g    = ack_right;
            assign start[g] = send_request && send_channel;
        end else begin : g_extra
            assign level_g  = 1'b1;
            assign ack_g    = 1'b0;
            assign start[g] = 1'b0;
        end

        osup_rx u_rx (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tick    (tick),
            .level   (level_g),
            .ack     (ack_g),
            .timing  (timing_reg),
            .ready   (ready[g]),
            .rx_byte (rx_byte[g])
        );

        osup_tx u_tx (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tick    (tick),
            .start   (start[g]),
            .tx_byte (send_byte),
            .timing  (timing_reg),
            .line    (line[g]),
            .busy    (busy[g])
        );
    end

    // Right channel fields, idle when only one channel is built
    if (CHANNELS > 1) begin : g_right_out
        assign tx_r    = line[1];
        assign ready_r = ready[1];
        assign byte_r  = rx_byte[1];
        assign busy_r  = busy[1];
    end else begin : g_right_idle
        assign tx_r    = 1'b1;
        assign ready_r = 1'b0;
        assign byte_r  = 8'd0;
        assign busy_r  = 1'b0;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, rejected_reg, busy_r, busy[0], byte_r, rx_byte[0],
                       ready_r, ready[0], tx_r, line[0]};

endmodule

// ===== dv/tb_oversampled_soft_uart_pair.sv =====
// Self-checking testbench for oversampled_soft_uart_pair: random and directed tick streams,
// checked against an in-bench model of both serial channels. Depends on osup_pkg and the RTL.
`timescale 1ns / 1ps

module tb_oversampled_soft_uart_pair;
    import osup_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    // One oversampling tick as seen by the block, channel 0 = left
    typedef struct packed {
        logic [1:0] rx;
        logic       req;
        logic       ch;
        logic [7:0] data;
        logic [1:0] ack;
    } tick_t;

    // Line and status view after one tick
    typedef struct packed {
        logic [1:0] tx;
        logic [1:0] ready;
        logic [7:0] rbyte_l;
        logic [7:0] rbyte_r;
        logic [1:0] busy;
        logic       rejected;
    } line_status_t;

    typedef bit level_seq_t[$];

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [TICK_W-1:0]      cfg_data = '0;

    // Line status expected for every accepted tick, oldest first
    line_status_t expected_status[$];
    int mismatch_count = 0;
    int result_count = 0;
    int cycles = 0;
    int unsigned stall_left = 0;
    bit quiet = 1'b0;

    // Planned receive line levels per channel
    level_seq_t wave_l;
    level_seq_t wave_r;

    // Channel model state and timing registers
    logic [7:0] first_ticks;
    logic [7:0] bit_period;
    rx_phase_t  rx_ph [2];
    logic [7:0] rx_cnt [2];
    logic [3:0] rx_idx [2];
    logic [7:0] rx_shift [2];
    tx_phase_t  tx_ph [2];
    logic [7:0] tx_cnt [2];
    logic [3:0] tx_idx [2];
    logic [7:0] tx_data [2];
    logic       tx_line [2];

    oversampled_soft_uart_pair #(
        .CHANNELS (2)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- model

    task automatic reset_channels();
        first_ticks = FIRST_SAMPLE_RST;
        bit_period  = BIT_TICKS_RST;
        for (int c = 0; c < 2; c++) begin
            rx_ph[c]    = RX_IDLE;
            rx_cnt[c]   = '0;
            rx_idx[c]   = '0;
            rx_shift[c] = '0;
            tx_ph[c]    = TX_IDLE;
            tx_cnt[c]   = '0;
            tx_idx[c]   = '0;
            tx_data[c]  = '0;
            tx_line[c]  = 1'b1;
        end
    endtask

    function automatic bit tx_busy(int c);
        return (tx_ph[c] == TX_SEND) || (tx_ph[c] == TX_LAST);
    endfunction

    // Advance one receiver by one tick
    function automatic void rx_advance(int c, logic level);
        case (rx_ph[c])
            RX_IDLE: begin
                if (!level) begin
                    rx_ph[c]    = RX_SAMPLE;
                    rx_cnt[c]   = first_ticks;
                    rx_idx[c]   = '0;
                    rx_shift[c] = '0;
                end
            end
            RX_SAMPLE: begin
                if (rx_cnt[c] <= 8'd1) begin
                    rx_shift[c][rx_idx[c][2:0]] = rx_shift[c][rx_idx[c][2:0]] | level;
                    rx_cnt[c] = bit_period;
                    rx_idx[c] = rx_idx[c] + 4'd1;
                    if (rx_idx[c] >= DATA_BITS)
                        rx_ph[c] = RX_STOP;
                end else begin
                    rx_cnt[c] = rx_cnt[c] - 8'd1;
                end
            end
            RX_STOP: begin
                if (level)
                    rx_ph[c] = RX_HOLD;
            end
            default: ;
        endcase
    endfunction

    // Advance one transmitter by one tick: start bit, then data LSB first
    function automatic void tx_advance(int c);
        logic [3:0] k;
        if (tx_ph[c] == TX_SEND) begin
            if (tx_cnt[c] <= 8'd1) begin
                k = tx_idx[c] - 4'd1;
                tx_line[c] = (tx_idx[c] == 4'd0) ? 1'b0 : tx_data[c][k[2:0]];
                tx_idx[c] = tx_idx[c] + 4'd1;
                tx_cnt[c] = bit_period;
                if (tx_idx[c] >= TX_LAST_INDEX)
                    tx_ph[c] = TX_LAST;
            end else begin
                tx_cnt[c] = tx_cnt[c] - 8'd1;
            end
        end else if (tx_ph[c] == TX_LAST) begin
            if (tx_cnt[c] <= 8'd1) begin
                tx_line[c] = 1'b1;
                tx_ph[c] = TX_IDLE;
            end else begin
                tx_cnt[c] = tx_cnt[c] - 8'd1;
            end
        end
    endfunction

    // Apply acks and the send request, then tick both channels
    function automatic line_status_t uart_pair_step(tick_t t);
        line_status_t st;
        st = '0;
        for (int c = 0; c < 2; c++)
            if (t.ack[c] && rx_ph[c] == RX_HOLD)
                rx_ph[c] = RX_IDLE;
        if (t.req) begin
            if (tx_busy(t.ch)) begin
                st.rejected = 1'b1;
            end else begin
                tx_data[t.ch] = t.data;
                tx_idx[t.ch]  = '0;
                tx_cnt[t.ch]  = '0;
                tx_ph[t.ch]   = TX_SEND;
            end
        end
        for (int c = 0; c < 2; c++) begin
            rx_advance(c, t.rx[c]);
            tx_advance(c);
            st.tx[c]    = tx_line[c];
            st.ready[c] = (rx_ph[c] == RX_HOLD);
            st.busy[c]  = tx_busy(c);
        end
        st.rbyte_l = st.ready[0] ? rx_shift[0] : 8'h00;
        st.rbyte_r = st.ready[1] ? rx_shift[1] : 8'h00;
        return st;
    endfunction

    // ---------------------------------------------------------------- drivers

    // Mostly short gaps, a few long ones, none while quiet
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    // Send one tick request and record its expected line status
    task automatic send_tick(input tick_t t);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {3'b000, t.ack[1], t.ack[0], t.data, t.req, t.rx[1], t.rx[0]};
        s_tuser  <= t.ch;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_status.push_back(uart_pair_step(t));
    endtask

    // Hold off new requests until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FIRST_SAMPLE)
            first_ticks = value;
        else
            bit_period = value;
    endtask

    // Drain, load both timing registers and drop stale line plans
    task automatic set_timing(input logic [7:0] first, input logic [7:0] bits);
        wait_drained();
        write_reg(REG_FIRST_SAMPLE, first);
        @(posedge aclk);
        write_reg(REG_BIT_TICKS, bits);
        wave_l.delete();
        wave_r.delete();
    endtask

    // Plan a stretch of receive line: idle, noise, or a frame at the current timing
    function automatic level_seq_t plan_line_wave();
        level_seq_t w;
        logic [7:0] value;
        int r;
        int n;
        r = $urandom_range(0, 99);
        value = 8'($urandom);
        if (r < 30) begin
            n = $urandom_range(1, 12);
            repeat (n) w.push_back(1'b1);
        end else if (r < 36) begin
            n = $urandom_range(1, 8);
            repeat (n) w.push_back(1'($urandom_range(0, 1)));
        end else begin
            // start bit long enough that samples land on bit boundaries
            repeat (first_ticks) w.push_back(1'b0);
            for (int k = 0; k < 8; k++)
                repeat (bit_period) w.push_back(value[k]);
            // broken frame: stop bit held low for a while
            if (r < 46) begin
                n = $urandom_range(1, bit_period + 3);
                repeat (n) w.push_back(1'b0);
            end
            repeat (bit_period) w.push_back(1'b1);
        end
        return w;
    endfunction

    task automatic run_random_ticks(input int count);
        tick_t t;
        for (int i = 0; i < count; i++) begin
            if (wave_l.size() == 0)
                wave_l = plan_line_wave();
            if (wave_r.size() == 0)
                wave_r = plan_line_wave();
            t.rx[0] = wave_l.pop_front();
            t.rx[1] = wave_r.pop_front();
            for (int c = 0; c < 2; c++)
                t.ack[c] = ($urandom_range(0, 99) < ((rx_ph[c] == RX_HOLD) ? 30 : 4));
            t.ch   = 1'($urandom_range(0, 1));
            t.data = 8'($urandom);
            t.req  = ($urandom_range(0, 99) < (tx_busy(t.ch) ? 4 : 25));
            send_tick(t);
            // occasionally let the pipe run dry before going on
            if ($urandom_range(0, 299) == 0)
                wait_drained();
        end
    endtask

    // ---------------------------------------------------------------- tests

    // Reset timing values, no register writes yet
    task automatic test_reset_defaults();
        run_random_ticks(220);
    endtask

    // Fastest timing: full bytes 0xFF/0x00, reject on busy, acks with nothing held,
    // stop bit held low, then sends of both extreme bytes and a received mixed frame
    task automatic test_directed_edges();
        tick_t seq [25];
        logic [7:0] mixed;
        mixed = 8'hA5;
        set_timing(8'd1, 8'd1);
        for (int i = 0; i < 25; i++) begin
            seq[i] = '0;
            seq[i].rx = 2'b11;
        end
        seq[0].rx = 2'b00;
        seq[0].req = 1'b1;
        seq[0].ch = 1'b0;
        seq[0].data = 8'h00;
        for (int i = 1; i <= 9; i++)
            seq[i].rx = 2'b01;
        seq[10].rx = 2'b01;
        seq[1].req = 1'b1;
        seq[1].ch = 1'b0;
        seq[1].data = 8'h55;
        seq[2].req = 1'b1;
        seq[2].ch = 1'b1;
        seq[2].data = 8'hFF;
        seq[3].ack = 2'b11;
        seq[10].ack = 2'b01;
        seq[12].ack = 2'b11;
        seq[13].req = 1'b1;
        seq[13].ch = 1'b0;
        seq[13].data = 8'hFF;
        seq[14].req = 1'b1;
        seq[14].ch = 1'b1;
        seq[14].data = 8'h00;
        seq[15].rx[0] = 1'b0;
        for (int k = 0; k < 8; k++)
            seq[16 + k].rx[0] = mixed[k];
        seq[16].req = 1'b1;
        seq[16].ch = 1'b0;
        seq[16].data = 8'h3C;
        for (int i = 0; i < 25; i++)
            send_tick(seq[i]);
    endtask

    // Short timings so that many whole frames pass; one setting without any idling
    task automatic test_small_timings();
        set_timing(8'd3, 8'd2);
        run_random_ticks(130);
        set_timing(8'd2, 8'd3);
        quiet = 1'b1;
        run_random_ticks(130);
        quiet = 1'b0;
        set_timing(8'd6, 8'd4);
        run_random_ticks(130);
        set_timing(8'd1, 8'd1);
        run_random_ticks(130);
    endtask

    // Counter extremes: long first sample, long bits, both long
    task automatic test_extreme_timings();
        set_timing(8'd255, 8'd1);
        run_random_ticks(140);
        set_timing(8'd1, 8'd255);
        run_random_ticks(140);
        set_timing(8'd255, 8'd255);
        run_random_ticks(160);
    endtask

    // Random short timings to finish
    task automatic test_mixed_timings();
        for (int i = 0; i < 2; i++) begin
            set_timing(8'($urandom_range(1, 8)), 8'($urandom_range(1, 6)));
            run_random_ticks(110);
        end
    endtask

    // ---------------------------------------------------------------- checking

    // Random backpressure on the result side
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 99) < 18) begin
            m_tready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                      : $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            if (mismatch_count < 10)
                $display("result %0d: %s expected %0h, got %0h", result_count, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin
        line_status_t want;
        line_status_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.tx       = m_tdata[1:0];
            got.ready    = m_tdata[3:2];
            got.rbyte_l  = m_tdata[11:4];
            got.rbyte_r  = m_tdata[19:12];
            got.busy     = m_tdata[21:20];
            got.rejected = m_tdata[22];
            if (expected_status.size() == 0) begin
                if (mismatch_count < 10)
                    $display("result %0d arrived with nothing expected", result_count);
                mismatch_count++;
            end else begin
                want = expected_status.pop_front();
                check_field("tx_left", want.tx[0], got.tx[0]);
                check_field("tx_right", want.tx[1], got.tx[1]);
                check_field("ready_left", want.ready[0], got.ready[0]);
                check_field("ready_right", want.ready[1], got.ready[1]);
                check_field("byte_left", want.rbyte_l, got.rbyte_l);
                check_field("byte_right", want.rbyte_r, got.rbyte_r);
                check_field("busy_left", want.busy[0], got.busy[0]);
                check_field("busy_right", want.busy[1], got.busy[1]);
                check_field("send_rejected", want.rejected, got.rejected);
            end
            result_count++;
        end
    end

    // Give up on a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        reset_channels();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_edges();
        test_small_timings();
        test_extreme_timings();
        test_mixed_timings();
        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
